FILE: rtl/dmx512_frame_transmitter_macros.svh
// ----------------------------------------------------------------------------
// DMX512 transmitter assertion macros
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DMX512_FRAME_TRANSMITTER_MACROS_SVH
`define DMX512_FRAME_TRANSMITTER_MACROS_SVH

`ifndef SYNTHESIS

// Checks that the consequent holds in the same cycle as the antecedent.
`define DMX_TX_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmx512_frame_transmitter: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define DMX_TX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmx512_frame_transmitter: next-cycle check failed");

`else

`define DMX_TX_ASSERT_SAME(lbl, ante, cons)
`define DMX_TX_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/dmx_tx_pkg.sv
// ----------------------------------------------------------------------------
// DMX512 transmitter package
// Types, register indexes, reset values and field widths of the transmitter.
// ----------------------------------------------------------------------------
package dmx_tx_pkg;

    localparam int NUM_SLOTS_DEF = 513;

    localparam int PERIOD_W    = 16;
    localparam int BREAK_W     = 10;
    localparam int MAB_W       = 8;
    localparam int TAIL_W      = 8;
    localparam int BIT_W       = 4;
    localparam int SLOT_CNT_W  = 10;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int TIMER_W     = 10;
    localparam int BITPOS_W    = 4;
    localparam int INDEX_W     = 10;
    localparam int BYTE_W      = 8;

    localparam logic [PERIOD_W-1:0]   FRAME_PERIOD_RST = 16'd40000;
    localparam logic [BREAK_W-1:0]    BREAK_RST        = 10'd88;
    localparam logic [MAB_W-1:0]      MAB_RST          = 8'd8;
    localparam logic [TAIL_W-1:0]     TAIL_RST         = 8'd44;
    localparam logic [BIT_W-1:0]      BIT_RST          = 4'd4;
    localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RST   = 10'd513;

    // Bit positions within one slot: start bit, eight data bits, two stop bits.
    localparam logic [BITPOS_W-1:0] BITPOS_START     = 4'd0;
    localparam logic [BITPOS_W-1:0] BITPOS_LAST_DATA = 4'd8;
    localparam logic [BITPOS_W-1:0] BITPOS_LAST_STOP = 4'd10;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BREAK,
        PH_MAB,
        PH_DATA,
        PH_TAIL
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_PERIOD = 3'd0,
        CFG_BREAK        = 3'd1,
        CFG_MAB          = 3'd2,
        CFG_TAIL         = 3'd3,
        CFG_BIT          = 3'd4,
        CFG_SLOT_COUNT   = 3'd5
    } cfg_index_t;

endpackage

FILE: rtl/dmx512_frame_transmitter.sv
// ----------------------------------------------------------------------------
// DMX512 frame transmitter
// Generates DMX512 frames on a serial line from a slot store, paced by ticks.
// ----------------------------------------------------------------------------
// Each input transaction is either a one-microsecond tick or a write into the
// slot store, and each one produces exactly one result transaction that shows
// the line level, the driver enable, the busy flag and the frame-done pulse.
// The block takes one transaction per clock unless a stall holds it back:
// the item is captured in an input register, and once the result register
// is free or being emptied, the frame sequencer advances and the result
// register is loaded. The next item may be captured in the same cycle, so a
// steady stream runs at one item per clock as long as the result side keeps
// up. The slot store is a single memory of NUM_SLOTS bytes. After reset a
// clearing pass zeroes it one entry per clock; in_stall stays high for that
// time, while configuration writes are taken as usual. The memory
// is read every cycle at the address of the next slot the sequencer will
// load, so a byte is ready whenever a slot begins; a write to that same
// address in the cycle of the read is forwarded into the read register.
// Configuration is written through a plain write port and must only change
// while no transaction is in flight. A change in the middle of a frame takes
// effect as each phase or bit is entered, and the slot count is checked at
// the end of each slot.
// ----------------------------------------------------------------------------
`include "dmx512_frame_transmitter_macros.svh"

module dmx512_frame_transmitter #(
    parameter int NUM_SLOTS = dmx_tx_pkg::NUM_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [dmx_tx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [dmx_tx_pkg::CFG_DATA_W-1:0]   cfg_data,

    // Input channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [dmx_tx_pkg::INDEX_W-1:0]      slot_index,
    input  logic [dmx_tx_pkg::BYTE_W-1:0]       slot_value,

    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                line_level,
    output logic                                drive_enable,
    output logic                                busy_res,
    output logic                                frame_done
);

    localparam int ADDR_W = $clog2(NUM_SLOTS);
    localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = dmx_tx_pkg::SLOT_CNT_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_SLOTS - 1);
    localparam logic [CMP_W-1:0]  NUM_SLOTS_CMP = CMP_W'(NUM_SLOTS);

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    logic [dmx_tx_pkg::PERIOD_W-1:0]   frame_period_reg;
    logic [dmx_tx_pkg::BREAK_W-1:0]    break_reg;
    logic [dmx_tx_pkg::MAB_W-1:0]      mab_reg;
    logic [dmx_tx_pkg::TAIL_W-1:0]     tail_reg;
    logic [dmx_tx_pkg::BIT_W-1:0]      bit_reg;
    logic [dmx_tx_pkg::SLOT_CNT_W-1:0] slot_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_period_reg <= dmx_tx_pkg::FRAME_PERIOD_RST;
            break_reg        <= dmx_tx_pkg::BREAK_RST;
            mab_reg          <= dmx_tx_pkg::MAB_RST;
            tail_reg         <= dmx_tx_pkg::TAIL_RST;
            bit_reg          <= dmx_tx_pkg::BIT_RST;
            slot_count_reg   <= dmx_tx_pkg::SLOT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            // Indexes beyond the register list are ignored.
            unique case (cfg_index)
                dmx_tx_pkg::CFG_FRAME_PERIOD:
                    frame_period_reg <= cfg_data[dmx_tx_pkg::PERIOD_W-1:0];
                dmx_tx_pkg::CFG_BREAK:
                    break_reg <= cfg_data[dmx_tx_pkg::BREAK_W-1:0];
                dmx_tx_pkg::CFG_MAB:
                    mab_reg <= cfg_data[dmx_tx_pkg::MAB_W-1:0];
                dmx_tx_pkg::CFG_TAIL:
                    tail_reg <= cfg_data[dmx_tx_pkg::TAIL_W-1:0];
                dmx_tx_pkg::CFG_BIT:
                    bit_reg <= cfg_data[dmx_tx_pkg::BIT_W-1:0];
                dmx_tx_pkg::CFG_SLOT_COUNT:
                    slot_count_reg <= cfg_data[dmx_tx_pkg::SLOT_CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Handshake and input register.
    // ------------------------------------------------------------------------
    logic                              clearing_reg;
    logic [ADDR_W-1:0]                 clear_addr_reg;
    logic                              item_valid_reg;
    logic                              item_opcode_reg;
    logic [dmx_tx_pkg::INDEX_W-1:0]    item_index_reg;
    logic [dmx_tx_pkg::BYTE_W-1:0]     item_value_reg;
    logic                              out_valid_reg;
    logic                              process;
    logic                              in_accept;

    // The held item is processed whenever the result register is free or is
    // being emptied in this cycle.
    assign process   = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = clearing_reg || (item_valid_reg && !process);
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_opcode_reg <= opcode;
            item_index_reg  <= slot_index;
            item_value_reg  <= slot_value;
        end
    end

    // Clearing pass over the slot store after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clear_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer state.
    // ------------------------------------------------------------------------
    dmx_tx_pkg::phase_t                phase_reg, phase_next;
    logic [dmx_tx_pkg::TIMER_W-1:0]    timer_reg, timer_next;
    logic [dmx_tx_pkg::BITPOS_W-1:0]   bitpos_reg, bitpos_next;
    logic [PTR_W-1:0]                  ptr_reg, ptr_next;
    logic [dmx_tx_pkg::BYTE_W-1:0]     shift_reg, shift_next;
    logic [dmx_tx_pkg::PERIOD_W-1:0]   period_reg, period_next;
    logic                              pending_reg, pending_next;
    logic                              done_next;

    // ------------------------------------------------------------------------
    // Slot store and its read register.
    // ------------------------------------------------------------------------
    logic [dmx_tx_pkg::BYTE_W-1:0]     slot_mem [NUM_SLOTS];
    logic [dmx_tx_pkg::BYTE_W-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]                 rd_addr;
    logic [PTR_W-1:0]                  ptr_inc;
    logic                              mem_we;
    logic [ADDR_W-1:0]                 mem_waddr;
    logic [dmx_tx_pkg::BYTE_W-1:0]     mem_wdata;
    logic                              host_write;

    assign ptr_inc = ptr_reg + PTR_W'(1);

    // The next slot to be loaded is slot zero outside the data phase and the
    // slot after the current one inside it. Once a slot is loaded at least
    // eleven ticks pass before the next load, so an address that changes on
    // one edge has been read again well before it is needed.
    always_comb
    begin
        if (phase_reg == dmx_tx_pkg::PH_DATA && CMP_W'(ptr_inc) < NUM_SLOTS_CMP)
        begin
            rd_addr = ptr_inc[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    assign host_write = process && (item_opcode_reg == dmx_tx_pkg::OP_WRITE)
                        && (CMP_W'(item_index_reg) < NUM_SLOTS_CMP);
    assign mem_we     = clearing_reg || host_write;
    assign mem_waddr  = clearing_reg ? clear_addr_reg : item_index_reg[ADDR_W-1:0];
    assign mem_wdata  = clearing_reg ? '0 : item_value_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && mem_waddr == rd_addr)
        begin
            rd_data_reg <= mem_wdata;
        end
        else
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Next-state logic for one tick.
    // ------------------------------------------------------------------------
    logic [dmx_tx_pkg::SLOT_CNT_W-1:0] slots_per_frame;
    logic [dmx_tx_pkg::TIMER_W-1:0]    bit_len_m1;
    logic                              is_tick;

    // A slot count of zero means one slot; a count above the store size is
    // clamped to the store size.
    always_comb
    begin
        if (slot_count_reg == '0)
        begin
            slots_per_frame = dmx_tx_pkg::SLOT_CNT_W'(1);
        end
        else if (CMP_W'(slot_count_reg) > NUM_SLOTS_CMP)
        begin
            slots_per_frame = dmx_tx_pkg::SLOT_CNT_W'(NUM_SLOTS);
        end
        else
        begin
            slots_per_frame = slot_count_reg;
        end
    end

    assign bit_len_m1 = (bit_reg == '0) ? '0
                        : dmx_tx_pkg::TIMER_W'(bit_reg - dmx_tx_pkg::BIT_W'(1));
    assign is_tick    = item_opcode_reg == dmx_tx_pkg::OP_TICK;

    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        bitpos_next  = bitpos_reg;
        ptr_next     = ptr_reg;
        shift_next   = shift_reg;
        period_next  = period_reg;
        pending_next = pending_reg;
        done_next    = 1'b0;

        if (is_tick)
        begin
            // Frame period counter; a period of zero makes every tick a start.
            if (period_reg == '0)
            begin
                pending_next = 1'b1;
                period_next  = (frame_period_reg == '0) ? '0
                               : frame_period_reg - dmx_tx_pkg::PERIOD_W'(1);
            end
            else
            begin
                period_next = period_reg - dmx_tx_pkg::PERIOD_W'(1);
            end

            if (phase_reg != dmx_tx_pkg::PH_IDLE && timer_reg != '0)
            begin
                timer_next = timer_reg - dmx_tx_pkg::TIMER_W'(1);
            end
            else
            begin
                unique case (phase_reg)
                    dmx_tx_pkg::PH_IDLE:
                    begin
                        if (pending_next)
                        begin
                            pending_next = 1'b0;
                            phase_next   = dmx_tx_pkg::PH_BREAK;
                            timer_next   = (break_reg == '0) ? '0
                                           : break_reg - dmx_tx_pkg::BREAK_W'(1);
                        end
                    end
                    dmx_tx_pkg::PH_BREAK:
                    begin
                        phase_next = dmx_tx_pkg::PH_MAB;
                        timer_next = (mab_reg == '0) ? '0
                                     : dmx_tx_pkg::TIMER_W'(mab_reg - dmx_tx_pkg::MAB_W'(1));
                    end
                    dmx_tx_pkg::PH_MAB:
                    begin
                        phase_next  = dmx_tx_pkg::PH_DATA;
                        ptr_next    = '0;
                        shift_next  = rd_data_reg;
                        bitpos_next = dmx_tx_pkg::BITPOS_START;
                        timer_next  = bit_len_m1;
                    end
                    dmx_tx_pkg::PH_DATA:
                    begin
                        if (bitpos_reg < dmx_tx_pkg::BITPOS_LAST_STOP)
                        begin
                            bitpos_next = bitpos_reg + dmx_tx_pkg::BITPOS_W'(1);
                            timer_next  = bit_len_m1;
                        end
                        else if (CMP_W'(ptr_inc) < CMP_W'(slots_per_frame))
                        begin
                            ptr_next    = ptr_inc;
                            shift_next  = rd_data_reg;
                            bitpos_next = dmx_tx_pkg::BITPOS_START;
                            timer_next  = bit_len_m1;
                        end
                        else if (tail_reg != '0)
                        begin
                            phase_next  = dmx_tx_pkg::PH_TAIL;
                            ptr_next    = ptr_inc;
                            bitpos_next = '0;
                            timer_next  = dmx_tx_pkg::TIMER_W'(tail_reg - dmx_tx_pkg::TAIL_W'(1));
                        end
                        else
                        begin
                            phase_next = dmx_tx_pkg::PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                    dmx_tx_pkg::PH_TAIL:
                    begin
                        phase_next = dmx_tx_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                    default:
                    begin
                        phase_next = dmx_tx_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end

            if (phase_next == dmx_tx_pkg::PH_IDLE)
            begin
                timer_next  = '0;
                bitpos_next = '0;
                ptr_next    = '0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output decode from the state after this item.
    // ------------------------------------------------------------------------
    logic line_next;
    logic busy_next;

    always_comb
    begin
        line_next = 1'b1;
        unique case (phase_next)
            dmx_tx_pkg::PH_BREAK:
            begin
                line_next = 1'b0;
            end
            dmx_tx_pkg::PH_DATA:
            begin
                if (bitpos_next == dmx_tx_pkg::BITPOS_START)
                begin
                    line_next = 1'b0;
                end
                else if (bitpos_next <= dmx_tx_pkg::BITPOS_LAST_DATA)
                begin
                    line_next = shift_next[3'(bitpos_next - dmx_tx_pkg::BITPOS_W'(1))];
                end
            end
            default:
            begin
                line_next = 1'b1;
            end
        endcase
        busy_next = phase_next != dmx_tx_pkg::PH_IDLE;
    end

    // ------------------------------------------------------------------------
    // State and result registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= dmx_tx_pkg::PH_IDLE;
            timer_reg   <= '0;
            bitpos_reg  <= '0;
            ptr_reg     <= '0;
            shift_reg   <= '0;
            period_reg  <= '0;
            pending_reg <= 1'b1;
        end
        else if (process)
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            bitpos_reg  <= bitpos_next;
            ptr_reg     <= ptr_next;
            shift_reg   <= shift_next;
            period_reg  <= period_next;
            pending_reg <= pending_next;
        end
    end

    logic line_reg;
    logic drive_reg;
    logic busy_reg;
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            line_reg  <= line_next;
            drive_reg <= busy_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_level   = line_reg;
    assign drive_enable = drive_reg;
    assign busy_res     = busy_reg;
    assign frame_done   = done_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // The line is only pulled low while the driver is enabled.
    `DMX_TX_ASSERT_SAME(a_low_needs_driver, out_valid_reg && !line_reg, drive_reg)
    // The release result shows an idle, released, high line.
    `DMX_TX_ASSERT_SAME(a_done_released, out_valid_reg && done_reg,
                        !drive_reg && !busy_reg && line_reg)
    // The bit position never runs past the second stop bit.
    `DMX_TX_ASSERT_SAME(a_bitpos_range, phase_reg == dmx_tx_pkg::PH_DATA,
                        bitpos_reg <= dmx_tx_pkg::BITPOS_LAST_STOP)
    // A held item that cannot move on is kept for the next cycle.
    `DMX_TX_ASSERT_NEXT(a_item_held, item_valid_reg && !process,
                        item_valid_reg && $stable(item_opcode_reg))

endmodule
